// ----- rtl/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, codes and the tangent table of the grid ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

	// Default parameter values
	localparam int DEF_MAP_W     = 8;
	localparam int DEF_MAP_H     = 8;
	localparam int DEF_TILE_SIZE = 64;
	localparam int DEF_MAX_STEPS = 8;

	// Fixed widths
	localparam int CW      = 32;   // walk coordinate width, signed Q.8
	localparam int SLOPE_W = 24;   // Q8.16 slope magnitude
	localparam int ROM_N   = 1025;
	localparam int ROM_AW  = 11;
	localparam int PACK_RB = 3;    // row/column bits of the 8-wide tile packing

	// Binary angle landmarks
	localparam logic [11:0] ANG_ZERO = 12'd0;
	localparam logic [11:0] ANG_QTR  = 12'd1024;
	localparam logic [11:0] ANG_HALF = 12'd2048;
	localparam logic [11:0] ANG_3QTR = 12'd3072;

	// Multiply targets
	localparam logic [1:0] MUL_HX0 = 2'd0;
	localparam logic [1:0] MUL_HDX = 2'd1;
	localparam logic [1:0] MUL_VY0 = 2'd2;
	localparam logic [1:0] MUL_VDY = 2'd3;

	// Square operands
	localparam logic [1:0] SQ_HX = 2'd0;
	localparam logic [1:0] SQ_HY = 2'd1;
	localparam logic [1:0] SQ_VX = 2'd2;
	localparam logic [1:0] SQ_VY = 2'd3;

	// Partial products of a square
	localparam logic [1:0] PART_HH = 2'd0;
	localparam logic [1:0] PART_HL = 2'd1;
	localparam logic [1:0] PART_LL = 2'd2;

	// Walk select
	localparam logic WALK_H = 1'b0;
	localparam logic WALK_V = 1'b1;

	typedef struct packed {
		logic       load;
		logic       rom_hi;
		logic       cap_tr;
		logic       cap_tc;
		logic       mul_go;
		logic [1:0] mul_sel;
		logic       walk_go;
		logic       walk_sel;
		logic       sq_go;
		logic [1:0] sq_sel;
		logic [1:0] sq_part;
		logic       sqrt_go;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic walk_end;
		logic sqrt_done;
	} stat_t;

	typedef logic [SLOPE_W-1:0] slope_rom_t [ROM_N];

	// Unsigned shift-and-subtract quotient, table build only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sin(j*pi/2048) in Q30 by Taylor series
	function automatic logic [63:0] sin_q30(input int unsigned j);
		logic [63:0] x;
		logic [63:0] term;
		longint      sum;
		x    = (64'(j) * 64'hC90FDAA2) >> 11;
		term = x;
		sum  = longint'(x);
		for (int unsigned n = 1; n <= 8; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
			if (n[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return (sum < 0) ? 64'd0 : 64'(sum);
	endfunction

	// Rounded, saturated Q8.16 tangent of k units
	function automatic logic [63:0] tan_q16(input int unsigned k);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		num = sin_q30(k) << 16;
		den = sin_q30(1024 - k);
		if (den == 64'd0)
			return 64'hFF_FFFF;
		q = udiv64(num + (den >> 1), den);
		return (q > 64'hFF_FFFF) ? 64'hFF_FFFF : q;
	endfunction

	function automatic slope_rom_t tan_table();
		slope_rom_t  t;
		logic [63:0] v;
		for (int k = 0; k < ROM_N; k++) begin
			v    = tan_q16(k);
			t[k] = v[SLOPE_W-1:0];
		end
		return t;
	endfunction

	localparam slope_rom_t TAN_ROM = tan_table();

endpackage

// ----- rtl/grc_sqrt.sv -----
// ----------------------------------------------------------------------------
// grc_sqrt
// Bit-serial integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module grc_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic [31:0] root,
	output logic        done
);

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign done  = (bit_q == 64'd0);
	assign root  = res_q[31:0];

	// Active bit marker doubles as the busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bit_q <= '0;
		else if (start)
			bit_q <= 64'd1 << 62;
		else
			bit_q <= bit_q >> 2;
	end

	// Restoring iteration
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
		end else if (!done) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

// ----- rtl/grc_dp.sv -----
// ----------------------------------------------------------------------------
// grc_dp
// Datapath: slope lookup, slope multiplier, grid walks, squares, root.
// ----------------------------------------------------------------------------
module grc_dp
	import grc_pkg::*;
#(
	parameter int MAP_W     = DEF_MAP_W,
	parameter int MAP_H     = DEF_MAP_H,
	parameter int TILE_SIZE = DEF_TILE_SIZE,
	parameter int MAX_STEPS = DEF_MAX_STEPS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output stat_t        stat,
	input  logic [16:0]  origin_x,
	input  logic [16:0]  origin_y,
	input  logic [11:0]  ray_angle,
	input  logic [127:0] tile_map,
	output logic [23:0]  hit_distance,
	output logic [23:0]  hit_x,
	output logic [23:0]  hit_y,
	output logic         hit_horizontal,
	output logic [1:0]   wall_type
);

	localparam int LC   = $clog2(TILE_SIZE) + 8;  // log2 of a cell in Q.8
	localparam int AW   = LC + 1;
	localparam int PW   = AW + SLOPE_W;
	localparam int RW   = PW - 15;
	localparam int IW   = CW + 4;
	localparam int NT   = MAP_W * MAP_H;
	localparam int IXW  = $clog2(NT);
	localparam int CNTW = $clog2(MAX_STEPS + 1);
	localparam int HW   = CW / 2;
	localparam logic [AW-1:0]        CELL_A = AW'(1) << LC;
	localparam logic signed [CW-1:0] CELL_S = CW'(1) << LC;
	localparam logic [CW-1:0]        FMASK  = (CW'(1) << LC) - CW'(1);

	// Item registers
	logic [16:0]         px_q, py_q;
	logic [11:0]         ang_q;
	logic [SLOPE_W-1:0]  tr_q, tc_q, rom_q;
	logic signed [CW-1:0] hx_q, hy_q, vx_q, vy_q, hdx_q, vdy_q;
	logic [1:0]          hwall_q, vwall_q;
	logic [CNTW-1:0]     cnt_q;
	logic [63:0]         dh_q, dv_q;
	logic                hor_q;
	logic [PW-1:0]       prod_s1;
	logic                neg_s1, mvld_s1;
	logic [1:0]          msel_s1;
	logic [CW-1:0]       sqp_s1;
	logic [1:0]          sqpart_s1;
	logic                sqv_s1, sqvld_s1;

	// Angle decode
	logic odd, hvalid, vvalid, hdown, vleft;
	logic [ROM_AW-1:0] rom_addr;
	logic [SLOPE_W-1:0] cot_mag, tan_mag;

	assign odd     = ang_q[10];
	assign hvalid  = (ang_q != ANG_ZERO) && (ang_q != ANG_HALF);
	assign vvalid  = (ang_q != ANG_QTR) && (ang_q != ANG_3QTR);
	assign hdown   = ang_q > ANG_HALF;
	assign vleft   = (ang_q > ANG_QTR) && (ang_q < ANG_3QTR);
	assign cot_mag = odd ? tr_q : tc_q;
	assign tan_mag = odd ? tc_q : tr_q;
	assign rom_addr = cmd.rom_hi ? (ROM_AW'(ANG_QTR) - ROM_AW'(ang_q[9:0]))
	                             : ROM_AW'(ang_q[9:0]);

	// Slope table read
	always_ff @(posedge clk) begin
		rom_q <= TAN_ROM[rom_addr];
	end

	// First crossings on the grid
	logic signed [CW-1:0] base_x, base_y;
	logic [AW-1:0] hoff, voff;
	assign base_y = signed'(CW'(py_q) & ~FMASK);
	assign base_x = signed'(CW'(px_q) & ~FMASK);
	assign hoff = hdown ? (AW'(py_q[LC-1:0]) + AW'(1)) : (CELL_A - AW'(py_q[LC-1:0]));
	assign voff = vleft ? (AW'(px_q[LC-1:0]) + AW'(1)) : (CELL_A - AW'(px_q[LC-1:0]));

	// Slope multiplier operands
	logic [AW-1:0]      m_a;
	logic               m_an;
	logic [SLOPE_W-1:0] m_s;
	always_comb begin
		case (cmd.mul_sel)
			MUL_HX0: begin m_a = hoff;   m_an = hdown; m_s = cot_mag; end
			MUL_HDX: begin m_a = CELL_A; m_an = hdown; m_s = cot_mag; end
			MUL_VY0: begin m_a = voff;   m_an = vleft; m_s = tan_mag; end
			default: begin m_a = CELL_A; m_an = vleft; m_s = tan_mag; end
		endcase
	end

	// Round half away from zero to Q.8
	logic [PW:0]          rsum;
	logic [RW-1:0]        rmag;
	logic signed [CW-1:0] mval;
	assign rsum = {1'b0, prod_s1} + (PW+1)'(32768);
	assign rmag = rsum[PW:16];
	assign mval = neg_s1 ? -signed'(CW'(rmag)) : signed'(CW'(rmag));

	// Walk step: tile index of the current point
	logic signed [CW-1:0] wx, wy, row_c, col_c;
	logic signed [IW-1:0] idx_c;
	logic                 wval, inr;
	logic [IXW-1:0]       ix;
	logic [PACK_RB-1:0]   r_c, c_c;
	logic [1:0]           tile;
	logic                 at_max;
	assign wx     = cmd.walk_sel ? vx_q : hx_q;
	assign wy     = cmd.walk_sel ? vy_q : hy_q;
	assign wval   = cmd.walk_sel ? vvalid : hvalid;
	assign row_c  = wy >>> LC;
	assign col_c  = wx >>> LC;
	assign idx_c  = IW'(row_c) * IW'(MAP_W) + IW'(col_c);
	assign inr    = (idx_c >= 0) && (idx_c < IW'(NT));
	assign ix     = idx_c[IXW-1:0];
	assign at_max = (cnt_q == CNTW'(MAX_STEPS));

	always_comb begin
		r_c = '0;
		for (int k = 1; k < MAP_H; k++) begin
			if ((IXW+1)'(ix) >= (IXW+1)'(k * MAP_W))
				r_c = PACK_RB'(k);
		end
	end
	assign c_c  = PACK_RB'(ix - IXW'(int'(r_c) * MAP_W));
	assign tile = tile_map[{r_c, c_c, 1'b0} +: 2];

	assign stat.walk_end = !wval || at_max || !inr || (tile != 2'd0);

	// Square operand: offset magnitude split in halves
	logic signed [CW:0] dif;
	logic [CW:0]        dmag;
	logic [HW-1:0]      s_hi, s_lo, s_a, s_b;
	always_comb begin
		case (cmd.sq_sel)
			SQ_HX:   dif = {hx_q[CW-1], hx_q} - signed'((CW+1)'(px_q));
			SQ_HY:   dif = {hy_q[CW-1], hy_q} - signed'((CW+1)'(py_q));
			SQ_VX:   dif = {vx_q[CW-1], vx_q} - signed'((CW+1)'(px_q));
			default: dif = {vy_q[CW-1], vy_q} - signed'((CW+1)'(py_q));
		endcase
	end
	assign dmag = dif[CW] ? (CW+1)'(-dif) : (CW+1)'(dif);
	assign s_hi = dmag[CW-1:HW];
	assign s_lo = dmag[HW-1:0];
	assign s_a  = (cmd.sq_part == PART_LL) ? s_lo : s_hi;
	assign s_b  = (cmd.sq_part == PART_HH) ? s_hi : s_lo;

	logic [63:0] sq_add;
	always_comb begin
		case (sqpart_s1)
			PART_HH: sq_add = 64'(sqp_s1) << CW;
			PART_HL: sq_add = 64'(sqp_s1) << (HW + 1);
			default: sq_add = 64'(sqp_s1);
		endcase
	end

	// Nearer walk and root
	logic        hor_c;
	logic [31:0] root;
	logic        sq_done;
	assign hor_c = hvalid && (!vvalid || (dh_q < dv_q));

	grc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_go),
		.value  (hor_c ? dh_q : dv_q),
		.root   (root),
		.done   (sq_done)
	);
	assign stat.sqrt_done = sq_done;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			mvld_s1  <= 1'b0;
			sqvld_s1 <= 1'b0;
		end else begin
			mvld_s1  <= cmd.mul_go;
			sqvld_s1 <= cmd.sq_go;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.walk_go) begin
				if (stat.walk_end)
					cnt_q <= '0;
				else
					cnt_q <= cnt_q + CNTW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q    <= origin_x;
			py_q    <= origin_y;
			ang_q   <= ray_angle;
			hwall_q <= '0;
			vwall_q <= '0;
			dh_q    <= '0;
			dv_q    <= '0;
		end
		if (cmd.cap_tr)
			tr_q <= rom_q;
		if (cmd.cap_tc) begin
			tc_q <= rom_q;
			hy_q <= hdown ? (base_y - CW'(1)) : (base_y + CELL_S);
			vx_q <= vleft ? (base_x - CW'(1)) : (base_x + CELL_S);
			hx_q <= signed'(CW'(px_q));
			vy_q <= signed'(CW'(py_q));
		end

		// Slope product, applied in the next cycle
		if (cmd.mul_go) begin
			prod_s1 <= PW'(m_a) * PW'(m_s);
			neg_s1  <= m_an ^ odd;
			msel_s1 <= cmd.mul_sel;
		end
		if (mvld_s1) begin
			case (msel_s1)
				MUL_HX0: hx_q  <= signed'(CW'(px_q)) + mval;
				MUL_HDX: hdx_q <= mval;
				MUL_VY0: vy_q  <= signed'(CW'(py_q)) + mval;
				default: vdy_q <= mval;
			endcase
		end

		// Walk step
		if (cmd.walk_go) begin
			if (stat.walk_end) begin
				if (wval && !at_max && inr) begin
					if (cmd.walk_sel == WALK_V)
						vwall_q <= tile;
					else
						hwall_q <= tile;
				end
			end else if (cmd.walk_sel == WALK_V) begin
				vx_q <= vleft ? (vx_q - CELL_S) : (vx_q + CELL_S);
				vy_q <= vy_q + vdy_q;
			end else begin
				hx_q <= hx_q + hdx_q;
				hy_q <= hdown ? (hy_q - CELL_S) : (hy_q + CELL_S);
			end
		end

		// Squares, accumulated in the next cycle
		if (cmd.sq_go) begin
			sqp_s1    <= CW'(s_a) * CW'(s_b);
			sqpart_s1 <= cmd.sq_part;
			sqv_s1    <= cmd.sq_sel[1];
		end
		if (sqvld_s1) begin
			if (sqv_s1)
				dv_q <= dv_q + sq_add;
			else
				dh_q <= dh_q + sq_add;
		end

		if (cmd.sqrt_go)
			hor_q <= hor_c;
	end

	// Result fields
	function automatic logic [23:0] sat24(input logic signed [CW-1:0] v);
		if (v > signed'(CW'(8388607)))
			return 24'h7F_FFFF;
		if (v < -signed'(CW'(8388608)))
			return 24'h80_0000;
		return v[23:0];
	endfunction

	assign hit_distance   = (root[31:24] != 8'd0) ? 24'hFF_FFFF : root[23:0];
	assign hit_x          = sat24(hor_q ? hx_q : vx_q);
	assign hit_y          = sat24(hor_q ? hy_q : vy_q);
	assign hit_horizontal = hor_q;
	assign wall_type      = hor_q ? hwall_q : vwall_q;

endmodule

// ----- rtl/grc_ctrl.sv -----
// ----------------------------------------------------------------------------
// grc_ctrl
// Sequencer: steps one ray through lookup, walks, squares and root.
// ----------------------------------------------------------------------------
module grc_ctrl
	import grc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  out_free,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ROM0  = 4'd1;
	localparam logic [3:0] S_ROM1  = 4'd2;
	localparam logic [3:0] S_ROM2  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_MULW  = 4'd5;
	localparam logic [3:0] S_WALKH = 4'd6;
	localparam logic [3:0] S_WALKV = 4'd7;
	localparam logic [3:0] S_SQ    = 4'd8;
	localparam logic [3:0] S_SQW   = 4'd9;
	localparam logic [3:0] S_ROOT0 = 4'd10;
	localparam logic [3:0] S_ROOT  = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;

	logic [3:0] state_q, state_d;
	logic [1:0] mcnt_q, sel_q, part_q;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = mcnt_q;
		cmd.sq_sel  = sel_q;
		cmd.sq_part = part_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid)
					state_d = S_ROM0;
			end
			S_ROM0: state_d = S_ROM1;
			S_ROM1: begin
				cmd.cap_tr = 1'b1;
				cmd.rom_hi = 1'b1;
				state_d    = S_ROM2;
			end
			S_ROM2: begin
				cmd.cap_tc = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				if (mcnt_q == MUL_VDY)
					state_d = S_MULW;
			end
			S_MULW: state_d = S_WALKH;
			S_WALKH: begin
				cmd.walk_go  = 1'b1;
				cmd.walk_sel = WALK_H;
				if (stat.walk_end)
					state_d = S_WALKV;
			end
			S_WALKV: begin
				cmd.walk_go  = 1'b1;
				cmd.walk_sel = WALK_V;
				if (stat.walk_end)
					state_d = S_SQ;
			end
			S_SQ: begin
				cmd.sq_go = 1'b1;
				if (sel_q == SQ_VY && part_q == PART_LL)
					state_d = S_SQW;
			end
			S_SQW: state_d = S_ROOT0;
			S_ROOT0: begin
				cmd.sqrt_go = 1'b1;
				state_d     = S_ROOT;
			end
			S_ROOT: begin
				if (stat.sqrt_done)
					state_d = S_FIN;
			end
			S_FIN: begin
				cmd.out_load = out_free;
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and sub-step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mcnt_q  <= '0;
			sel_q   <= '0;
			part_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.mul_go)
				mcnt_q <= mcnt_q + 2'd1;
			if (cmd.sq_go) begin
				if (part_q == PART_LL) begin
					part_q <= PART_HH;
					sel_q  <= sel_q + 2'd1;
				end else begin
					part_q <= part_q + 2'd1;
				end
			end
		end
	end

endmodule

// ----- rtl/grid_ray_caster_unit.sv -----
// One ray at a time: s_tready rises again in the cycle after a result is loaded.
// A finished result waits in the output register while the next ray runs.
// Reset (arst_n, asynchronous, active low) clears control and tile map.
// ----------------------------------------------------------------------------
// grid_ray_caster_unit
// Casts one ray per input through a tile map and reports the nearer wall.
// ----------------------------------------------------------------------------
module grid_ray_caster_unit
	import grc_pkg::*;
#(
	parameter int MAP_W     = DEF_MAP_W,
	parameter int MAP_H     = DEF_MAP_H,
	parameter int TILE_SIZE = DEF_TILE_SIZE,
	parameter int MAX_STEPS = DEF_MAX_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // origin_x[16:0], origin_y[33:17], ray_angle[45:34]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // hit_distance[23:0], hit_x[47:24], hit_y[71:48],
	                               // wall_type[73:72]
	output logic        m_tuser,   // hit_horizontal
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	cmd_t  cmd;
	stat_t stat;

	logic [63:0] rows03_q, rows47_q;
	logic        wr_en;
	logic [23:0] r_dist, r_x, r_y;
	logic        r_hor;
	logic [1:0]  r_wall;
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic        m_tuser_q;

	// Tile map registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = paddr[3] ? rows47_q : rows03_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows03_q <= '0;
			rows47_q <= '0;
		end else if (wr_en) begin
			if (paddr[3])
				rows47_q <= pwdata;
			else
				rows03_q <= pwdata;
		end
	end

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (!m_tvalid_q || m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	grc_dp #(
		.MAP_W     (MAP_W),
		.MAP_H     (MAP_H),
		.TILE_SIZE (TILE_SIZE),
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.origin_x       (s_tdata[16:0]),
		.origin_y       (s_tdata[33:17]),
		.ray_angle      (s_tdata[45:34]),
		.tile_map       ({rows47_q, rows03_q}),
		.hit_distance   (r_dist),
		.hit_x          (r_x),
		.hit_y          (r_y),
		.hit_horizontal (r_hor),
		.wall_type      (r_wall)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {6'd0, r_wall, r_y, r_x, r_dist};
			m_tuser_q <= r_hor;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a pending transfer");
	a_accept_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !cmd.out_load)
		else $error("input accepted while a result is loaded");
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && !cmd.out_load))
		else $error("sequencer did not start after input transfer");
`endif

endmodule

// ----- tb/grid_ray_caster_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_ray_caster_unit_tb
// Self-checking bench for the grid ray caster. Rays are sent on the input
// stream, each one is cast by a local model of the two grid walks over the
// current tile map, and every result transfer is compared field by field
// with the oldest predicted hit. The map is rewritten over the register port
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module grid_ray_caster_unit_tb;
	import grc_pkg::*;

	localparam int  CLK_HALF   = 5;
	localparam int  IDLE_PCT   = 17;
	localparam int  HOLD_LEN   = 300;
	localparam int  DRAIN_WAIT = 100;
	localparam int  STALL_MAX  = 3000;
	localparam int  TILE_PX    = 64;
	localparam int  MAP_N      = 8;
	localparam int  WALK_STEPS = 8;
	localparam longint CELL_Q8 = TILE_PX * 256;
	localparam logic [3:0] ADDR_ROWS_0_3 = 4'd0;
	localparam logic [3:0] ADDR_ROWS_4_7 = 4'd8;

	typedef struct packed {
		logic [23:0] hit_dist;
		logic [23:0] px;
		logic [23:0] py;
		logic        horiz;
		logic [1:0]  wall;
	} ray_hit_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// model state
	logic [63:0] map_lo;
	logic [63:0] map_hi;
	longint      slope_tab [1025];
	ray_hit_t    pending_hits [$];
	int          err_cnt;
	bit          no_idle;
	bit          hold_req;

	grid_ray_caster_unit u_dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// sin(j*pi/2048) in Q30, Taylor series
	function automatic longint sine_q30(int unsigned j);
		longint unsigned x;
		longint unsigned term;
		longint          sum;
		x    = (longint'(j) * 64'hC90FDAA2) >> 11;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return (sum < 0) ? 0 : sum;
	endfunction

	function automatic longint slope_of(int unsigned k);
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		num = longint'(sine_q30(k)) << 16;
		den = sine_q30(1024 - k);
		if (den == 0)
			return 64'hFF_FFFF;
		q = (num + den / 2) / den;
		return (q > 64'hFF_FFFF) ? 64'hFF_FFFF : longint'(q);
	endfunction

	// Q.8 times Q8.16, rounded half away from zero
	function automatic longint apply_slope(longint a, longint s);
		bit              neg;
		longint unsigned ma;
		longint unsigned ms;
		longint unsigned p;
		neg = (a < 0) != (s < 0);
		ma  = (a < 0) ? -a : a;
		ms  = (s < 0) ? -s : s;
		p   = (ma * ms + 32768) >> 16;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint div_floor(longint v, longint d);
		longint q;
		q = v / d;
		if (v % d != 0 && v < 0)
			q--;
		return q;
	endfunction

	function automatic void grid_walk(inout longint x, inout longint y, input longint dx,
			input longint dy, inout logic [1:0] wall);
		longint     idx;
		int         row;
		int         col;
		logic [1:0] t;
		for (int s = 0; s < WALK_STEPS; s++) begin
			idx = div_floor(y, CELL_Q8) * MAP_N + div_floor(x, CELL_Q8);
			if (idx < 0 || idx >= MAP_N * MAP_N)
				return;
			row = idx / MAP_N;
			col = idx % MAP_N;
			t   = (row < 4) ? map_lo[2 * (8 * (row % 4) + col) +: 2]
			                : map_hi[2 * (8 * (row % 4) + col) +: 2];
			if (t != 2'd0) begin
				wall = t;
				return;
			end
			x += dx;
			y += dy;
		end
	endfunction

	function automatic longint unsigned sq_dist(longint x, longint y, longint ox, longint oy);
		longint unsigned mx;
		longint unsigned my;
		mx = (x < ox) ? ox - x : x - ox;
		my = (y < oy) ? oy - y : y - oy;
		return mx * mx + my * my;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [23:0] clamp24(longint v);
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[23:0];
	endfunction

	// expected nearer wall crossing of one ray
	function automatic ray_hit_t cast_ray(logic [16:0] ox_in, logic [16:0] oy_in,
			logic [11:0] ang);
		ray_hit_t        h;
		longint          ox;
		longint          oy;
		int unsigned     r;
		longint          tn;
		longint          ct;
		bit              h_ok;
		bit              v_ok;
		bit              hor;
		longint          hx;
		longint          hy;
		longint          vx;
		longint          vy;
		longint          stp;
		longint          base;
		logic [1:0]      hw;
		logic [1:0]      vw;
		longint unsigned dh;
		longint unsigned dv;
		longint unsigned d;
		ox   = ox_in;
		oy   = oy_in;
		r    = ang[9:0];
		tn   = ang[10] ? -slope_tab[1024 - r] : slope_tab[r];
		ct   = ang[10] ? -slope_tab[r] : slope_tab[1024 - r];
		h_ok = (ang != ANG_ZERO && ang != ANG_HALF);
		v_ok = (ang != ANG_QTR && ang != ANG_3QTR);
		hx = ox; hy = oy; vx = ox; vy = oy;
		hw = 2'd0; vw = 2'd0; dh = 0; dv = 0;
		// walk over horizontal grid lines
		if (h_ok) begin
			base = div_floor(oy, CELL_Q8) * CELL_Q8;
			if (ang > ANG_HALF) begin
				hy  = base - 1;
				stp = -CELL_Q8;
			end else begin
				hy  = base + CELL_Q8;
				stp = CELL_Q8;
			end
			hx = ox + apply_slope(hy - oy, ct);
			grid_walk(hx, hy, apply_slope(stp, ct), stp, hw);
			dh = sq_dist(hx, hy, ox, oy);
		end
		// walk over vertical grid lines
		if (v_ok) begin
			base = div_floor(ox, CELL_Q8) * CELL_Q8;
			if (ang > ANG_QTR && ang < ANG_3QTR) begin
				vx  = base - 1;
				stp = -CELL_Q8;
			end else begin
				vx  = base + CELL_Q8;
				stp = CELL_Q8;
			end
			vy = oy + apply_slope(vx - ox, tn);
			grid_walk(vx, vy, stp, apply_slope(stp, tn), vw);
			dv = sq_dist(vx, vy, ox, oy);
		end
		hor        = h_ok && (!v_ok || dh < dv);
		d          = int_sqrt(hor ? dh : dv);
		h.hit_dist = (d > 64'hFF_FFFF) ? 24'hFF_FFFF : d[23:0];
		h.px       = clamp24(hor ? hx : vx);
		h.py       = clamp24(hor ? hy : vy);
		h.horiz    = hor;
		h.wall     = hor ? hw : vw;
		return h;
	endfunction

	// one ray transfer, with random gaps before it
	task automatic send_ray(logic [16:0] ox, logic [16:0] oy, logic [11:0] ang);
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < 50);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, ang, oy, ox};
		do
			@(posedge clk);
		while (!s_tready);
		pending_hits.push_back(cast_ray(ox, oy, ang));
	endtask

	task automatic end_stream();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		end_stream();
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic reg_write(logic [3:0] addr, logic [63:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_ROWS_0_3)
			map_lo = val;
		else
			map_hi = val;
	endtask

	task automatic load_map(logic [63:0] lo, logic [63:0] hi);
		wait_drained();
		reg_write(ADDR_ROWS_0_3, lo);
		reg_write(ADDR_ROWS_4_7, hi);
	endtask

	function automatic logic [11:0] pick_angle();
		logic [11:0] lm [8] = '{ANG_ZERO, ANG_QTR, ANG_HALF, ANG_3QTR,
		                        12'd1, 12'd1023, 12'd2049, 12'd4095};
		if ($urandom_range(99) < 10)
			return lm[$urandom_range(7)];
		return 12'($urandom);
	endfunction

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_ray(17'($urandom), 17'($urandom), pick_angle());
	endtask

	// landmark angles from extreme origins on the reset map, then from one inner origin on a full map
	task automatic test_directed();
		logic [11:0] angs [12] = '{ANG_ZERO, ANG_QTR, ANG_HALF, ANG_3QTR, 12'd1,
		                          12'd1023, 12'd1025, 12'd2047, 12'd2049, 12'd3071,
		                          12'd3073, 12'd4095};
		foreach (angs[i])
			send_ray((i % 2) ? 17'h1FFFF : 17'h0, (i % 3 == 0) ? 17'h1FFFF : 17'h0, angs[i]);
		load_map('1, '1);
		foreach (angs[i])
			send_ray(17'h10080, 17'h0C040, angs[i]);
	endtask

	// random rays on several maps, border walls, sparse and dense
	task automatic test_random_maps();
		load_map(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
		send_random(100);
		// walls of type 1..3 around the border
		load_map(64'h8002_8002_8002_5555, 64'hFFFF_C003_C003_C003);
		send_random(150);
		load_map({$urandom, $urandom} & {$urandom, $urandom},
		         {$urandom, $urandom} & {$urandom, $urandom});
		no_idle = 1'b1;
		send_random(120);
		no_idle = 1'b0;
		load_map({$urandom, $urandom}, {$urandom, $urandom});
		send_random(150);
		load_map(64'h0, {$urandom, $urandom});
		send_random(176);
	endtask

	// receiver stalls for a long time while rays keep coming
	task automatic test_backpressure();
		load_map({$urandom, $urandom} & 64'h3333_0000_CCCC_0000, '1);
		hold_req = 1'b1;
		send_random(30);
	endtask

	// result receiver readiness
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// result check against the oldest predicted hit
	always @(posedge clk) begin
		ray_hit_t exp_h;
		ray_hit_t got_h;
		if (arst_n && m_tvalid && m_tready) begin
			got_h = '{m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tuser,
			          m_tdata[73:72]};
			if (pending_hits.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got_h);
				err_cnt++;
			end else begin
				exp_h = pending_hits.pop_front();
				if (exp_h.hit_dist !== got_h.hit_dist || exp_h.px !== got_h.px
				    || exp_h.py !== got_h.py || exp_h.horiz !== got_h.horiz
				    || exp_h.wall !== got_h.wall) begin
					$display("%0t: mismatch exp dist=%h x=%h y=%h hor=%b wall=%0d",
					         $time, exp_h.hit_dist, exp_h.px, exp_h.py, exp_h.horiz,
					         exp_h.wall);
					$display("%0t:          got dist=%h x=%h y=%h hor=%b wall=%0d",
					         $time, got_h.hit_dist, got_h.px, got_h.py, got_h.horiz,
					         got_h.wall);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int quiet_cyc;
		quiet_cyc = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= STALL_MAX) begin
				$display("[grid_ray_caster_unit] ERROR");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		map_lo   = '0;
		map_hi   = '0;
		err_cnt  = 0;
		no_idle  = 1'b0;
		hold_req = 1'b0;
		for (int k = 0; k < 1025; k++)
			slope_tab[k] = slope_of(k);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_maps();
		test_backpressure();
		wait_drained();
		if (err_cnt == 0)
			$display("[grid_ray_caster_unit] OK");
		else
			$display("[grid_ray_caster_unit] ERROR");
		$finish;
	end

endmodule
